FILE: sv/bcc_pkg.sv
// shared types and constants for the key-toggled rgb color cycler
// no dependencies
`default_nettype none

package bcc_pkg;

    typedef enum logic [1:0] {
        CMD_EDGE = 2'd0,
        CMD_POLL = 2'd1,
        CMD_TICK = 2'd2,
        CMD_RSVD = 2'd3
    } bcc_cmd_t;

    typedef enum logic [1:0] {
        PHASE_RG   = 2'd0,
        PHASE_GB   = 2'd1,
        PHASE_BR   = 2'd2,
        PHASE_NONE = 2'd3
    } bcc_phase_t;

    localparam logic [15:0] HOLD_MAX        = 16'hffff;
    localparam logic [7:0]  STEP_MAX        = 8'hff;
    localparam logic [15:0] LONG_PRESS_INIT = 16'd200;

    typedef struct packed {
        logic        seen_down;
        logic        seen_up;
        logic        key_held;
        logic [15:0] hold_count;
        logic        demo_active;
        logic        long_flag;
        bcc_phase_t  fade_phase;
        logic [7:0]  fade_step;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } bcc_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pwm_written;
        logic       demo_on;
        logic       long_press;
    } bcc_result_t;

endpackage

`default_nettype wire

FILE: sv/button_toggled_rgb_color_cycler_top.sv
// top level: input register, update core, result register, threshold register
// depends on bcc_pkg and bcc_core
//
// channel   dir  signals                       contents
// s_axis    in   s_tvalid s_tready s_tdata     tuser[1:0] cmd, tdata[0] key_level_low
//                s_tuser
// m_axis    out  m_tvalid m_tready m_tdata     red, green, blue, pwm_written, demo_on,
//                                              long_press
// cfg       in   cfg_we cfg_wdata              long_press_ticks
//
// one beat per cycle sustained while m_tready keeps the result register draining; an accepted
// beat goes to the input register, then through the single-pass update into the result register
// all cycler state updates when a beat moves from the input to the result register
// the input side stalls only when both registers hold beats and m_tready is low
// reset clears the valid flags and all cycler state, not the data registers; threshold returns to 200
`default_nettype none

module button_toggled_rgb_color_cycler_top
    import bcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] key_level_low
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [24] pwm_written, [25] demo_on, [26] long_press
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic        in_level_reg;
    logic        out_valid_reg;
    bcc_result_t out_data_reg;
    logic [15:0] thresh_reg;
    logic        advance;
    bcc_result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bcc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .cmd              (in_cmd_reg),
        .key_level_low    (in_level_reg),
        .long_press_ticks (thresh_reg),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= LONG_PRESS_INIT;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= s_tuser;
            in_level_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg.long_press, out_data_reg.demo_on,
                       out_data_reg.pwm_written, out_data_reg.blue,
                       out_data_reg.green, out_data_reg.red};

endmodule

`default_nettype wire

FILE: sv/bcc_core.sv
// state registers and single-pass update logic for one beat
// depends on bcc_pkg
`default_nettype none

module bcc_core
    import bcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [1:0]  cmd,
    input  wire logic        key_level_low,
    input  wire logic [15:0] long_press_ticks,
    output bcc_result_t      result
);

    bcc_state_t state_reg;
    bcc_state_t state_next;
    logic       written;

    always_comb
    begin
        bcc_cmd_t op;
        logic     is_poll;
        op         = bcc_cmd_t'(cmd);
        is_poll    = (op == CMD_POLL) || (op == CMD_TICK);
        state_next = state_reg;
        written    = 1'b0;

        if (op == CMD_EDGE)
        begin
            if (key_level_low)
            begin
                state_next.seen_down = 1'b1;
            end
            else
            begin
                state_next.seen_up = 1'b1;
            end
            state_next.key_held = key_level_low;
        end

        if (is_poll && state_reg.seen_down && state_reg.seen_up)
        begin
            state_next.seen_down  = 1'b0;
            state_next.seen_up    = 1'b0;
            state_next.hold_count = '0;
            state_next.demo_active = !state_reg.demo_active;
            if (state_reg.demo_active)
            begin
                state_next.red   = '0;
                state_next.green = '0;
                state_next.blue  = '0;
                written          = 1'b1;
            end
        end

        if (op == CMD_TICK)
        begin
            if (state_reg.key_held && (state_next.hold_count != HOLD_MAX))
            begin
                state_next.hold_count = state_next.hold_count + 16'd1;
            end
            if (state_next.demo_active && (state_reg.fade_phase != PHASE_NONE))
            begin
                if (state_reg.fade_step == STEP_MAX)
                begin
                    state_next.fade_step = '0;
                    case (state_reg.fade_phase)
                        PHASE_RG: state_next.fade_phase = PHASE_GB;
                        PHASE_GB: state_next.fade_phase = PHASE_BR;
                        default:  state_next.fade_phase = PHASE_RG;
                    endcase
                end
                else
                begin
                    case (state_reg.fade_phase)
                        PHASE_RG:
                        begin
                            state_next.red   = STEP_MAX - state_reg.fade_step;
                            state_next.green = state_reg.fade_step;
                            state_next.blue  = '0;
                        end
                        PHASE_GB:
                        begin
                            state_next.red   = '0;
                            state_next.green = STEP_MAX - state_reg.fade_step;
                            state_next.blue  = state_reg.fade_step;
                        end
                        default:
                        begin
                            state_next.red   = state_reg.fade_step;
                            state_next.green = '0;
                            state_next.blue  = STEP_MAX - state_reg.fade_step;
                        end
                    endcase
                    state_next.fade_step = state_reg.fade_step + 8'd1;
                    written              = 1'b1;
                end
            end
        end

        if (is_poll && state_reg.key_held && (state_next.hold_count >= long_press_ticks))
        begin
            state_next.long_flag = 1'b1;
        end
    end

    assign result.red         = state_next.red;
    assign result.green       = state_next.green;
    assign result.blue        = state_next.blue;
    assign result.pwm_written = written;
    assign result.demo_on     = state_next.demo_active;
    assign result.long_press  = state_next.long_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bcc_checker.sv
// port-level checks for the color cycler top level, with its bind
// depends on button_toggled_rgb_color_cycler_top
`default_nettype none

module bcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic [9:0] rgb_sum;

    assign rgb_sum = 10'(m_tdata[7:0]) + 10'(m_tdata[15:8]) + 10'(m_tdata[23:16]);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input side never blocks while the result register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // demo off means leds dark
    a_dark_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[25] |-> m_tdata[23:0] == 24'd0)
        else $error("rgb nonzero while demo off");

    // every crossfade write splits full scale between two colors
    a_fade_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24] && m_tdata[25] |-> rgb_sum == 10'd255)
        else $error("crossfade colors do not sum to full scale");

    // long press is sticky
    a_long_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[26] ##1 m_tvalid |-> m_tdata[26])
        else $error("long press flag cleared");

endmodule

bind button_toggled_rgb_color_cycler_top bcc_checker u_bcc_checker (.*);

`default_nettype wire

FILE: sim/cycler_checker.sv
`timescale 1ns / 100ps
// checker for the key-toggled rgb color cycler: watches input, result and threshold ports,
// predicts every result beat and compares it field by field
// depends on bcc_pkg
module cycler_checker
    import bcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fails,
    output int          pending
);

    logic        key_down_seen;
    logic        key_up_seen;
    logic        key_held;
    logic [15:0] hold_ticks;
    logic        demo_run;
    logic        long_seen;
    bcc_phase_t  fade_ph;
    logic [7:0]  fade_pos;
    logic [7:0]  r_duty;
    logic [7:0]  g_duty;
    logic [7:0]  b_duty;
    logic [15:0] press_limit;

    bcc_result_t due_colors[$];
    bcc_result_t want;
    bcc_result_t got;
    int          fail_tally = 0;
    int          reported   = 0;

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    function automatic bcc_result_t advance_cycler(bcc_cmd_t op, logic pressed);
        bcc_result_t res;
        logic        wrote;
        wrote = 1'b0;
        if (op == CMD_EDGE)
        begin
            if (pressed)
            begin
                key_down_seen = 1'b1;
                key_held      = 1'b1;
            end
            else
            begin
                key_up_seen = 1'b1;
                key_held    = 1'b0;
            end
        end
        else if (op == CMD_POLL || op == CMD_TICK)
        begin
            if (key_down_seen && key_up_seen)
            begin
                key_down_seen = 1'b0;
                key_up_seen   = 1'b0;
                hold_ticks    = '0;
                if (!demo_run)
                    demo_run = 1'b1;
                else
                begin
                    demo_run = 1'b0;
                    r_duty   = '0;
                    g_duty   = '0;
                    b_duty   = '0;
                    wrote    = 1'b1;
                end
            end
            if (op == CMD_TICK)
            begin
                if (key_held && hold_ticks != HOLD_MAX)
                    hold_ticks = hold_ticks + 16'd1;
                if (demo_run && fade_ph != PHASE_NONE)
                begin
                    if (fade_pos == STEP_MAX)
                    begin
                        fade_pos = '0;
                        fade_ph  = (fade_ph == PHASE_BR) ? PHASE_RG
                                                         : bcc_phase_t'(fade_ph + 2'd1);
                    end
                    else
                    begin
                        case (fade_ph)
                            PHASE_RG:
                            begin
                                r_duty = STEP_MAX - fade_pos;
                                g_duty = fade_pos;
                                b_duty = '0;
                            end
                            PHASE_GB:
                            begin
                                r_duty = '0;
                                g_duty = STEP_MAX - fade_pos;
                                b_duty = fade_pos;
                            end
                            default:
                            begin
                                r_duty = fade_pos;
                                g_duty = '0;
                                b_duty = STEP_MAX - fade_pos;
                            end
                        endcase
                        fade_pos = fade_pos + 8'd1;
                        wrote    = 1'b1;
                    end
                end
            end
            if (key_held && hold_ticks >= press_limit)
                long_seen = 1'b1;
        end
        res.red         = r_duty;
        res.green       = g_duty;
        res.blue        = b_duty;
        res.pwm_written = wrote;
        res.demo_on     = demo_run;
        res.long_press  = long_seen;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_seen = 1'b0;
            key_up_seen   = 1'b0;
            key_held      = 1'b0;
            hold_ticks    = '0;
            demo_run      = 1'b0;
            long_seen     = 1'b0;
            fade_ph       = PHASE_RG;
            fade_pos      = '0;
            r_duty        = '0;
            g_duty        = '0;
            b_duty        = '0;
            press_limit   = LONG_PRESS_INIT;
            due_colors.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.red         = m_tdata[7:0];
                got.green       = m_tdata[15:8];
                got.blue        = m_tdata[23:16];
                got.pwm_written = m_tdata[24];
                got.demo_on     = m_tdata[25];
                got.long_press  = m_tdata[26];
                if (due_colors.size() == 0)
                begin
                    fail_tally++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result beat: tdata=%h", m_tdata);
                    end
                end
                else
                begin
                    want = due_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.pwm_written !== want.pwm_written
                        || got.demo_on !== want.demo_on || got.long_press !== want.long_press)
                    begin
                        fail_tally++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch: exp r=%0d g=%0d b=%0d w=%b d=%b l=%b",
                                     want.red, want.green, want.blue, want.pwm_written,
                                     want.demo_on, want.long_press);
                            $display("          got r=%0d g=%0d b=%0d w=%b d=%b l=%b",
                                     got.red, got.green, got.blue, got.pwm_written,
                                     got.demo_on, got.long_press);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_colors.push_back(advance_cycler(bcc_cmd_t'(s_tuser), s_tdata[0]));
            if (cfg_we)
                press_limit = cfg_wdata;
            pending <= due_colors.size();
            fails   <= fail_tally;
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench top for the key-toggled rgb color cycler: clock, reset, key and tick stimulus,
// result-side stalls and the verdict
// depends on bcc_pkg, button_toggled_rgb_color_cycler_top and cycler_checker
module tb;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int   fails;
    int   pending;
    int   beats_sent = 0;
    int   cycles     = 0;
    int   rx_left    = 0;
    int   rx_roll;
    logic steady     = 1'b0;

    button_toggled_rgb_color_cycler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    cycler_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_left  <= 0;
        end
        else if (rx_left != 0)
            rx_left <= rx_left - 1;
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 55)
            begin
                m_tready <= 1'b1;
                rx_left  <= $urandom_range(0, 8);
            end
            else if (rx_roll < 65)
            begin
                m_tready <= 1'b1;
                rx_left  <= $urandom_range(40, 120);
            end
            else if (rx_roll < 93)
            begin
                m_tready <= 1'b0;
                rx_left  <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b0;
                rx_left  <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic rand_bit();
        return $urandom_range(0, 1) != 0;
    endfunction

    function automatic bcc_cmd_t rand_poll();
        return ($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_POLL;
    endfunction

    task automatic send_beat(input bcc_cmd_t op, input logic level);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != CMD_RSVD)
            beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] ticks);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_mix(input int budget);
        int first;
        int n;
        int pick;
        first = beats_sent;
        while (beats_sent - first < budget)
        begin
            pick   = $urandom_range(0, 19);
            steady = ($urandom_range(0, 3) == 0);
            if (pick < 7)
            begin
                // press, optional polls while held, release, poll to toggle
                send_beat(CMD_EDGE, 1'b1);
                n = $urandom_range(0, 4);
                repeat (n) send_beat(rand_poll(), rand_bit());
                send_beat(CMD_EDGE, 1'b0);
                send_beat(rand_poll(), rand_bit());
            end
            else if (pick < 12)
            begin
                n = $urandom_range(1, 30);
                repeat (n) send_beat(($urandom_range(0, 7) == 0) ? CMD_POLL : CMD_TICK,
                                     rand_bit());
            end
            else if (pick < 15)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_beat(bcc_cmd_t'($urandom_range(0, 3)), rand_bit());
            end
            else if (pick < 17)
            begin
                send_beat(CMD_EDGE, rand_bit());
                send_beat(rand_poll(), rand_bit());
            end
            else if (pick == 17)
                drain_results();
            else if (pick == 18)
            begin
                n = $urandom_range(20, 60);
                repeat (n) send_beat(CMD_TICK, rand_bit());
            end
            else
            begin
                send_beat(CMD_EDGE, 1'b1);
                n = $urandom_range(1, 60);
                repeat (n) send_beat(CMD_TICK, rand_bit());
                send_beat(CMD_EDGE, 1'b0);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_RSVD, 1'b0);
        send_beat(CMD_RSVD, 1'b1);
        send_beat(CMD_POLL, 1'b0);
        send_beat(CMD_TICK, 1'b1);
        // release alone does not toggle
        send_beat(CMD_EDGE, 1'b0);
        send_beat(CMD_POLL, 1'b1);
        // press completes the pair: demo on
        send_beat(CMD_EDGE, 1'b1);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_POLL, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_RSVD, 1'b1);
        // demo off on a tick, colors cleared
        send_beat(CMD_EDGE, 1'b0);
        send_beat(CMD_EDGE, 1'b1);
        send_beat(CMD_TICK, 1'b1);
        // demo on again, fade resumes
        send_beat(CMD_EDGE, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_EDGE, 1'b1);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        // long fade run crosses a phase boundary with the key held
        repeat (260) send_beat(CMD_TICK, rand_bit());
        // release then poll: no press since the last toggle, so the demo stays on
        send_beat(CMD_EDGE, 1'b0);
        send_beat(CMD_POLL, 1'b0);
        send_beat(CMD_EDGE, 1'b1);
        send_beat(CMD_EDGE, 1'b0);

        write_threshold(HOLD_MAX);
        run_mix(45);
        write_threshold(16'd0);
        run_mix(45);
        write_threshold(16'd1);
        run_mix(45);
        write_threshold(16'($urandom_range(2, 1000)));
        run_mix(45);
        write_threshold(LONG_PRESS_INIT);
        run_mix(45);

        drain_results();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: button_toggled_rgb_color_cycler_top.f
sv/bcc_pkg.sv
sv/bcc_core.sv
sv/button_toggled_rgb_color_cycler_top.sv
sv/bcc_checker.sv
sim/cycler_checker.sv
sim/tb.sv
